// ----- rtl/core/skt_pkg.sv -----
package skt_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int ENTRY_W  = 9;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_DUP    = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic rd_mid;
        logic cmp_step;
        logic rd_pos;
        logic check;
        logic shift_up_step;
        logic shift_down_step;
        logic write_new;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic search_more;
        logic is_clear;
        logic is_insert;
        logic is_remove;
        logic hit;
        logic full;
        logic up_more;
        logic down_more;
        logic pend;
        logic out_busy;
    } dp_stat_t;

endpackage

// ----- rtl/core/skt_ctrl.sv -----
module skt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  skt_pkg::dp_stat_t  stat,
    output skt_pkg::dp_cmd_t   cmd
);
    import skt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_CHECK,
        S_DECIDE,
        S_SHIFT_UP,
        S_WRITE_NEW,
        S_SHIFT_DOWN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    assign s_tready = ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH_RD;
                end
            end
            S_SEARCH_RD: begin
                if (stat.is_clear) begin
                    state_next = S_FINISH;
                end else if (stat.search_more) begin
                    cmd.rd_mid = 1'b1;
                    state_next = S_SEARCH_CMP;
                end else begin
                    cmd.rd_pos = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_SEARCH_CMP: begin
                cmd.cmp_step = 1'b1;
                state_next   = S_SEARCH_RD;
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.is_insert && !stat.hit && !stat.full) begin
                    state_next = S_SHIFT_UP;
                end else if (stat.is_remove && stat.hit) begin
                    state_next = S_SHIFT_DOWN;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_UP: begin
                cmd.shift_up_step = 1'b1;
                if (!stat.up_more && !stat.pend) begin
                    state_next = S_WRITE_NEW;
                end
            end
            S_WRITE_NEW: begin
                cmd.write_new = 1'b1;
                state_next    = S_FINISH;
            end
            S_SHIFT_DOWN: begin
                cmd.shift_down_step = 1'b1;
                if (!stat.down_more && !stat.pend) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// ----- rtl/core/skt_datapath.sv -----
module skt_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  skt_pkg::dp_cmd_t                cmd,
    output skt_pkg::dp_stat_t               stat,
    // key [31:0], payload [63:32]
    input  logic [skt_pkg::S_TDATA_W-1:0]   s_tdata,
    // command [1:0]
    input  logic [skt_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // payload_out [31:0], entry_count [40:32], zero [47:41]
    output logic [skt_pkg::M_TDATA_W-1:0]   m_tdata,
    // status [1:0], found [2]
    output logic [skt_pkg::M_TUSER_W-1:0]   m_tuser
);
    import skt_pkg::*;

    logic [KEY_W-1:0] key_mem [CAPACITY];
    logic [PAY_W-1:0] pay_mem [CAPACITY];

    cmd_t             cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0] pay_in_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] hi_reg;
    logic [CNT_W-1:0] cur_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_addr_reg;
    logic             hit_reg;
    logic [PAY_W-1:0] hit_pay_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [PAY_W-1:0] pay_rd_reg;

    logic               out_valid_reg;
    status_t            status_reg;
    logic               found_reg;
    logic [PAY_W-1:0]   pay_out_reg;
    logic [ENTRY_W-1:0] count_reg;

    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] cur_m1;
    logic [CNT_W-1:0] cur_p1;
    logic             up_more;
    logic             down_more;
    logic             full;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_key;
    logic [PAY_W-1:0] wr_pay;

    status_t          status_next;
    logic [CNT_W-1:0] used_next;

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cur_m1    = cur_reg - CNT_W'(1);
    assign cur_p1    = cur_reg + CNT_W'(1);
    assign up_more   = (cur_reg > lo_reg);
    assign down_more = (cur_p1 < used_reg);
    assign full      = (used_reg >= CNT_W'(CAPACITY));

    assign stat.search_more = (lo_reg < hi_reg);
    assign stat.is_clear    = (cmd_reg == CMD_CLEAR);
    assign stat.is_insert   = (cmd_reg == CMD_INSERT);
    assign stat.is_remove   = (cmd_reg == CMD_REMOVE);
    assign stat.hit         = hit_reg;
    assign stat.full        = full;
    assign stat.up_more     = up_more;
    assign stat.down_more   = down_more;
    assign stat.pend        = pend_reg;
    assign stat.out_busy    = out_valid_reg;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.rd_mid) begin
            rd_en   = 1'b1;
            rd_addr = mid[IDX_W-1:0];
        end else if (cmd.rd_pos) begin
            rd_en   = 1'b1;
            rd_addr = lo_reg[IDX_W-1:0];
        end else if (cmd.shift_up_step && up_more) begin
            rd_en   = 1'b1;
            rd_addr = cur_m1[IDX_W-1:0];
        end else if (cmd.shift_down_step && down_more) begin
            rd_en   = 1'b1;
            rd_addr = cur_p1[IDX_W-1:0];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_key  = key_rd_reg;
        wr_pay  = pay_rd_reg;
        if ((cmd.shift_up_step || cmd.shift_down_step) && pend_reg) begin
            wr_en = 1'b1;
        end else if (cmd.write_new) begin
            wr_en   = 1'b1;
            wr_addr = lo_reg[IDX_W-1:0];
            wr_key  = key_reg;
            wr_pay  = pay_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            pay_mem[wr_addr] <= wr_pay;
        end
        if (rd_en) begin
            key_rd_reg <= key_mem[rd_addr];
            pay_rd_reg <= pay_mem[rd_addr];
        end
    end

    always_comb begin
        status_next = STAT_OK;
        used_next   = used_reg;
        case (cmd_reg)
            CMD_INSERT: begin
                if (hit_reg) begin
                    status_next = STAT_DUP;
                end else if (full) begin
                    status_next = STAT_FULL;
                end else begin
                    used_next = used_reg + CNT_W'(1);
                end
            end
            CMD_LOOKUP: begin
                if (!hit_reg) begin
                    status_next = STAT_ABSENT;
                end
            end
            CMD_REMOVE: begin
                if (!hit_reg) begin
                    status_next = STAT_ABSENT;
                end else begin
                    used_next = used_reg - CNT_W'(1);
                end
            end
            default: begin
                used_next = '0;
            end
        endcase
    end

    // request, search, check, shift and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg    <= cmd_t'(s_tuser);
            key_reg    <= s_tdata[KEY_W-1:0];
            pay_in_reg <= s_tdata[KEY_W +: PAY_W];
            lo_reg     <= '0;
            hi_reg     <= used_reg;
        end
        if (cmd.cmp_step) begin
            if (key_rd_reg < key_reg) begin
                lo_reg <= mid + CNT_W'(1);
            end else begin
                hi_reg <= mid;
            end
        end
        if (cmd.check) begin
            hit_reg     <= (lo_reg < used_reg) && (key_rd_reg == key_reg);
            hit_pay_reg <= pay_rd_reg;
            cur_reg     <= (cmd_reg == CMD_INSERT) ? used_reg : lo_reg;
        end
        if (cmd.shift_up_step) begin
            if (up_more) begin
                pend_addr_reg <= cur_reg[IDX_W-1:0];
                cur_reg       <= cur_m1;
            end
        end
        if (cmd.shift_down_step) begin
            if (down_more) begin
                pend_addr_reg <= cur_reg[IDX_W-1:0];
                cur_reg       <= cur_p1;
            end
        end
        if (cmd.finish) begin
            status_reg  <= (cmd_reg == CMD_CLEAR) ? STAT_OK : status_next;
            found_reg   <= (cmd_reg != CMD_CLEAR) && hit_reg;
            pay_out_reg <= ((cmd_reg != CMD_CLEAR) && hit_reg) ? hit_pay_reg : '0;
            count_reg   <= ENTRY_W'(used_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.check) begin
                pend_reg <= 1'b0;
            end else if (cmd.shift_up_step) begin
                pend_reg <= up_more;
            end else if (cmd.shift_down_step) begin
                pend_reg <= down_more;
            end
            if (cmd.finish) begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - ENTRY_W - PAY_W){1'b0}}, count_reg, pay_out_reg};
    assign m_tuser  = {found_reg, status_reg};

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid_reg)
        else $error("finished result not presented");

    a_up_above_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.shift_up_step && pend_reg) |-> ({1'b0, pend_addr_reg} > lo_reg))
        else $error("shift up wrote at or below insert slot");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !out_valid_reg)
        else $error("result overwritten before transfer");

endmodule

// ----- rtl/core/sorted_key_table.sv -----
// Each request runs a binary search over the used entries, then a check of the found slot;
// an insert then shifts the entries above that slot up one place and writes the new entry,
// a remove shifts them down over the removed one, and a clear skips the search. Requests
// are taken one at a time, s_tready only while idle; search and shift share one read port.
// Reset: aresetn (synchronous, active low) empties the table and the result
// register; entry memory is not cleared.
module sorted_key_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // key [31:0], payload [63:32]
    input  logic [skt_pkg::S_TDATA_W-1:0]   s_tdata,
    // command [1:0]
    input  logic [skt_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // payload_out [31:0], entry_count [40:32], zero [47:41]
    output logic [skt_pkg::M_TDATA_W-1:0]   m_tdata,
    // status [1:0], found [2]
    output logic [skt_pkg::M_TUSER_W-1:0]   m_tuser
);
    import skt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    skt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skt_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- dv/sorted_key_table_test.sv -----
module sorted_key_table_test;
    import skt_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        cmd_t             cmd;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } request_t;

    typedef struct {
        status_t            status;
        logic               found;
        logic [PAY_W-1:0]   pay;
        logic [ENTRY_W-1:0] count;
    } reply_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    request_t         pending[$];
    logic [KEY_W-1:0] live_keys[$];
    reply_t           replies[$];

    logic [KEY_W-1:0] tbl_key [CAPACITY];
    logic [PAY_W-1:0] tbl_pay [CAPACITY];
    int               tbl_used = 0;

    int total_items  = 0;
    int accepted_in  = 0;
    int errors       = 0;
    int quiet_cycles = 0;
    bit in_taken     = 1'b0;

    sorted_key_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // stimulus side: which keys are held once every queued request has run
    function automatic int live_index(logic [KEY_W-1:0] k);
        foreach (live_keys[i]) begin
            if (live_keys[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void queue_request(cmd_t cmd, logic [KEY_W-1:0] k,
                                          logic [PAY_W-1:0] p);
        request_t r;
        int       idx;
        idx   = live_index(k);
        r.cmd = cmd;
        r.key = k;
        r.pay = p;
        pending.push_back(r);
        case (cmd)
            CMD_INSERT: begin
                if (idx < 0 && live_keys.size() < CAPACITY) live_keys.push_back(k);
            end
            CMD_REMOVE: begin
                if (idx >= 0) live_keys.delete(idx);
            end
            CMD_CLEAR: begin
                live_keys.delete();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        do begin
            case ($urandom_range(0, 9))
                0:       k = $urandom_range(0, 31);
                1:       k = 32'hFFFF_FFFF - $urandom_range(0, 31);
                default: k = $urandom;
            endcase
        end while (live_index(k) >= 0);
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] held_key();
        if (live_keys.size() == 0) return fresh_key();
        return live_keys[$urandom_range(0, live_keys.size() - 1)];
    endfunction

    // neighbours of held keys probe the edges of the search
    function automatic logic [KEY_W-1:0] absent_key();
        logic [KEY_W-1:0] k;
        if (live_keys.size() == 0 || $urandom_range(0, 1) == 0) return fresh_key();
        k = held_key() + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
        if (live_index(k) >= 0) return fresh_key();
        return k;
    endfunction

    function automatic void mixed_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)      queue_request(CMD_INSERT, fresh_key(), $urandom);
        else if (pick < 40) queue_request(CMD_INSERT, held_key(), $urandom);
        else if (pick < 60) queue_request(CMD_LOOKUP, held_key(), $urandom);
        else if (pick < 70) queue_request(CMD_LOOKUP, absent_key(), $urandom);
        else if (pick < 90) queue_request(CMD_REMOVE, held_key(), $urandom);
        else if (pick < 98) queue_request(CMD_REMOVE, absent_key(), $urandom);
        else                queue_request(CMD_CLEAR, $urandom, $urandom);
    endfunction

    function automatic void fill_run();
        while (live_keys.size() < CAPACITY) queue_request(CMD_INSERT, fresh_key(), $urandom);
        repeat (4) queue_request(CMD_INSERT, fresh_key(), $urandom);
        queue_request(CMD_INSERT, held_key(), $urandom);
        repeat (8) queue_request(CMD_LOOKUP, held_key(), $urandom);
        queue_request(CMD_REMOVE, held_key(), $urandom);
        queue_request(CMD_INSERT, fresh_key(), $urandom);
        if ($urandom_range(0, 1) == 0) begin
            queue_request(CMD_CLEAR, $urandom, $urandom);
        end else begin
            repeat (40) queue_request(CMD_REMOVE, held_key(), $urandom);
        end
    endfunction

    // expected table behaviour
    function automatic reply_t table_apply(cmd_t cmd, logic [KEY_W-1:0] k,
                                           logic [PAY_W-1:0] p);
        reply_t r;
        int     lo;
        int     hi;
        int     mid;
        bit     hit;
        r.status = STAT_OK;
        r.found  = 1'b0;
        r.pay    = '0;
        if (cmd == CMD_CLEAR) begin
            tbl_used = 0;
        end else begin
            lo = 0;
            hi = tbl_used;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (tbl_key[mid] < k) lo = mid + 1;
                else hi = mid;
            end
            hit = (lo < tbl_used) && (tbl_key[lo] == k);
            if (hit) begin
                r.found = 1'b1;
                r.pay   = tbl_pay[lo];
            end
            case (cmd)
                CMD_INSERT: begin
                    if (hit) begin
                        r.status = STAT_DUP;
                    end else if (tbl_used >= CAPACITY) begin
                        r.status = STAT_FULL;
                    end else begin
                        for (int i = tbl_used; i > lo; i--) begin
                            tbl_key[i] = tbl_key[i-1];
                            tbl_pay[i] = tbl_pay[i-1];
                        end
                        tbl_key[lo] = k;
                        tbl_pay[lo] = p;
                        tbl_used++;
                    end
                end
                CMD_LOOKUP: begin
                    if (!hit) r.status = STAT_ABSENT;
                end
                default: begin
                    if (!hit) begin
                        r.status = STAT_ABSENT;
                    end else begin
                        for (int i = lo; i < tbl_used - 1; i++) begin
                            tbl_key[i] = tbl_key[i+1];
                            tbl_pay[i] = tbl_pay[i+1];
                        end
                        tbl_used--;
                    end
                end
            endcase
        end
        r.count = ENTRY_W'(tbl_used);
        return r;
    endfunction

    function automatic int sender_idle_pct();
        if (accepted_in < total_items / 3) return 37;
        if (accepted_in < 2 * total_items / 3) return 66;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accepted_in < total_items / 3) return 66;
        if (accepted_in < 2 * total_items / 3) return 37;
        return 0;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    always @(negedge aclk) begin
        request_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || in_taken) begin
                if (pending.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    next_req = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_req.pay, next_req.key};
                    s_tuser  <= next_req.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
            in_taken = 1'b0;
        end
    end

    always @(posedge aclk) begin
        reply_t want;
        bit     moved;
        if (aresetn) begin
            moved = 1'b0;
            if (s_tvalid && s_tready) begin
                replies.push_back(table_apply(cmd_t'(s_tuser), s_tdata[KEY_W-1:0],
                                              s_tdata[KEY_W +: PAY_W]));
                accepted_in++;
                in_taken = 1'b1;
                moved    = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (replies.size() == 0) begin
                    report_mismatch("unexpected transfer", 64'({m_tuser, m_tdata}), '0);
                end else begin
                    want = replies.pop_front();
                    if (m_tuser[1:0] != want.status)
                        report_mismatch("status", 64'(m_tuser[1:0]), 64'(want.status));
                    if (m_tuser[2] != want.found)
                        report_mismatch("found", 64'(m_tuser[2]), 64'(want.found));
                    if (m_tdata[31:0] != want.pay)
                        report_mismatch("payload_out", 64'(m_tdata[31:0]), 64'(want.pay));
                    if (m_tdata[40:32] != want.count)
                        report_mismatch("entry_count", 64'(m_tdata[40:32]),
                                        64'(want.count));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int random_start;
        int run_no;

        queue_request(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
        queue_request(CMD_INSERT, 32'h0000_0000, 32'h0000_0001);
        queue_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(CMD_LOOKUP, 32'h8000_0001, 32'h0000_0000);
        queue_request(CMD_REMOVE, 32'h8000_0000, 32'h0000_0000);
        queue_request(CMD_REMOVE, 32'h8000_0000, 32'h0000_0000);
        queue_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        queue_request(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_request(CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_request(CMD_REMOVE, 32'h5555_5555, 32'hFFFF_FFFF);
        queue_request(CMD_REMOVE, 32'hAAAA_AAAA, 32'h0000_0000);
        queue_request(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);

        random_start = pending.size();
        run_no       = 0;
        while (pending.size() - random_start < RANDOM_ITEMS) begin
            if (pending.size() - random_start < RANDOM_ITEMS - 400 &&
                (run_no == 2 || (run_no % 4 == 1 && $urandom_range(0, 2) == 0))) begin
                fill_run();
            end else begin
                repeat ($urandom_range(10, 60)) mixed_request();
            end
            run_no++;
        end
        total_items = pending.size();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_in < total_items || replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
